// ===== src/sym2x2_inverse_sqrt_normalized_macros.svh =====
// assertion macros for the normalized inverse square root block
`ifndef SYM2X2_INVERSE_SQRT_NORMALIZED_MACROS_SVH
`define SYM2X2_INVERSE_SQRT_NORMALIZED_MACROS_SVH

// implication checked on every clock edge outside reset
`define S2ISN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition that must never hold outside reset
`define S2ISN_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== src/s2isn_pkg.sv =====
// shared constants and cell payload types for the inverse square root pipeline
`default_nettype none
package s2isn_pkg;

  localparam int OutFrac  = 24;
  localparam int RootW    = 32;
  localparam int RadW     = 2 * RootW;
  localparam int QuoW     = 32;
  localparam int NumW     = 34;
  localparam int DividW   = NumW + OutFrac + 1;
  localparam int DenW     = 33;
  localparam int NumDiv   = 5;

  typedef struct packed {
    logic [RadW-1:0]  val;
    logic [RootW+1:0] rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [QuoW-1:0] num;
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic [DenW-1:0] den;
  } div_t;

endpackage
`default_nettype wire

// ===== src/s2isn_sqrt_cell.sv =====
// one digit step of the integer square root chain
`default_nettype none
module s2isn_sqrt_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  s2isn_pkg::sqrt_t  d_i,
  output s2isn_pkg::sqrt_t  q_o
);
  import s2isn_pkg::*;

  sqrt_t st_q, st_d;
  logic [RootW+3:0] rem_w, trial_w, diff_w;

  always_comb begin
    rem_w   = {d_i.rem, d_i.val[RadW-1 -: 2]};
    trial_w = {2'b00, d_i.root, 2'b01};
    diff_w  = rem_w - trial_w;
    st_d.val = {d_i.val[RadW-3:0], 2'b00};
    if (rem_w >= trial_w) begin
      st_d.rem  = diff_w[RootW+1:0];
      st_d.root = {d_i.root[RootW-2:0], 1'b1};
    end else begin
      st_d.rem  = rem_w[RootW+1:0];
      st_d.root = {d_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign q_o = st_q;
endmodule
`default_nettype wire

// ===== src/s2isn_div_cell.sv =====
// one quotient bit of the restoring divider chain
`default_nettype none
module s2isn_div_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  s2isn_pkg::div_t  d_i,
  output s2isn_pkg::div_t  q_o
);
  import s2isn_pkg::*;

  div_t st_q, st_d;
  logic [DenW:0] rem_w, diff_w;

  always_comb begin
    rem_w  = {d_i.rem, d_i.num[QuoW-1]};
    diff_w = rem_w - {1'b0, d_i.den};
    st_d.num = {d_i.num[QuoW-2:0], 1'b0};
    st_d.den = d_i.den;
    if (rem_w >= {1'b0, d_i.den}) begin
      st_d.rem = diff_w[DenW-1:0];
      st_d.quo = {d_i.quo[QuoW-2:0], 1'b1};
    end else begin
      st_d.rem = rem_w[DenW-1:0];
      st_d.quo = {d_i.quo[QuoW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign q_o = st_q;
endmodule
`default_nettype wire

// ===== src/sym2x2_inverse_sqrt_normalized.sv =====
// Normalized inverse square root of a symmetric 2x2 matrix: a fully pipelined chain of
// normalize, multiply, square root and divide cells. One request is taken every cycle unless
// the output stalls. The pipeline is made of the three 32-cell root chains (one root bit per
// cell, the second two running side by side) and the five 32-cell divider chains running side
// by side, plus the prescale and multiply stages. A stall on the output holds the whole
// pipeline. status_o = 1 marks a matrix that is not positive definite, with all other
// result fields zero.
`default_nettype none
`include "sym2x2_inverse_sqrt_normalized_macros.svh"
module sym2x2_inverse_sqrt_normalized (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [30:0] tensor_xx_i,
  input  logic [31:0] tensor_xy_i,
  input  logic [30:0] tensor_yy_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] root_xx_o,
  output logic [31:0] root_xy_o,
  output logic [30:0] root_yy_o,
  output logic [30:0] factor_large_o,
  output logic [30:0] factor_small_o,
  output logic        status_o
);
  import s2isn_pkg::*;

  localparam int NStage = 110;
  localparam int NCell  = RootW;

  logic en;
  logic [NStage-1:0] vld_q;

  assign en         = !(vld_q[NStage-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStage-2:0], in_valid_i};
    end
  end

  // input stage and normalizing shift (index 0 is the input register)
  logic [30:0] na_q [6];
  logic [30:0] nc_q [6];
  logic [30:0] nb_q [6];
  logic [30:0] nm_q [6];
  logic        nneg_q [6];
  logic        nz_q [6];
  logic [31:0] bm_w;
  logic [30:0] mx_w;

  always_comb begin
    bm_w = tensor_xy_i[31] ? (32'd0 - tensor_xy_i) : tensor_xy_i;
    mx_w = (tensor_xx_i > tensor_yy_i) ? tensor_xx_i : tensor_yy_i;
    if ({1'b0, mx_w} < bm_w) begin
      mx_w = bm_w[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_q[0]   <= tensor_xx_i;
      nc_q[0]   <= tensor_yy_i;
      nb_q[0]   <= bm_w[30:0];
      nm_q[0]   <= mx_w;
      nneg_q[0] <= tensor_xy_i[31];
      // all-zero matrix, or |b| = 2^31 which always outweighs a*c
      nz_q[0]   <= bm_w[31] || (mx_w == '0);
    end
  end

  for (genvar k = 1; k < 6; k++) begin : g_norm
    localparam int Sh = 32 >> k;
    logic hit;
    assign hit = (nm_q[k-1][30 -: Sh] == '0);
    always_ff @(posedge clk_i) begin
      if (en) begin
        na_q[k]   <= hit ? (na_q[k-1] << Sh) : na_q[k-1];
        nc_q[k]   <= hit ? (nc_q[k-1] << Sh) : nc_q[k-1];
        nb_q[k]   <= hit ? (nb_q[k-1] << Sh) : nb_q[k-1];
        nm_q[k]   <= hit ? (nm_q[k-1] << Sh) : nm_q[k-1];
        nneg_q[k] <= nneg_q[k-1];
        nz_q[k]   <= nz_q[k-1];
      end
    end
  end

  // products and determinant
  logic [61:0] ac1_q, bb1_q, det2_q;
  logic [31:0] sum1_q, sum2_q;
  logic [30:0] a1_q, c1_q, b1_q, a2_q, c2_q, b2_q;
  logic        neg1_q, z1_q, neg2_q, bad2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ac1_q  <= na_q[5] * nc_q[5];
      bb1_q  <= nb_q[5] * nb_q[5];
      sum1_q <= {1'b0, na_q[5]} + {1'b0, nc_q[5]};
      a1_q   <= na_q[5];
      c1_q   <= nc_q[5];
      b1_q   <= nb_q[5];
      neg1_q <= nneg_q[5];
      z1_q   <= nz_q[5];
      det2_q <= ac1_q - bb1_q;
      bad2_q <= z1_q || (ac1_q <= bb1_q);
      sum2_q <= sum1_q;
      a2_q   <= a1_q;
      c2_q   <= c1_q;
      b2_q   <= b1_q;
      neg2_q <= neg1_q;
    end
  end

  // root of the determinant
  sqrt_t sc [NCell+1];
  logic [30:0] sa_q [NCell];
  logic [30:0] sc2_q [NCell];
  logic [30:0] sb_q [NCell];
  logic [31:0] ssum_q [NCell];
  logic        sneg_q [NCell];
  logic        sbad_q [NCell];

  assign sc[0] = '{val: {2'b00, det2_q}, rem: '0, root: '0};

  for (genvar k = 0; k < NCell; k++) begin : g_sroot
    s2isn_sqrt_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(sc[k]), .q_o(sc[k+1]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        sa_q[k]   <= (k == 0) ? a2_q   : sa_q[k == 0 ? 0 : k-1];
        sc2_q[k]  <= (k == 0) ? c2_q   : sc2_q[k == 0 ? 0 : k-1];
        sb_q[k]   <= (k == 0) ? b2_q   : sb_q[k == 0 ? 0 : k-1];
        ssum_q[k] <= (k == 0) ? sum2_q : ssum_q[k == 0 ? 0 : k-1];
        sneg_q[k] <= (k == 0) ? neg2_q : sneg_q[k == 0 ? 0 : k-1];
        sbad_q[k] <= (k == 0) ? bad2_q : sbad_q[k == 0 ? 0 : k-1];
      end
    end
  end

  // radicands of q and r
  logic [30:0] s3_q, a3_q, c3_q, b3_q, s4_q, a4_q, c4_q, b4_q, s5_q, a5_q, c5_q, b5_q;
  logic [32:0] t3_q, t4_q, t5_q;
  logic [31:0] sum3_q;
  logic [63:0] den4_q, sq4_q, den5_q, rr5_q;
  logic [61:0] ss4_q;
  logic        neg3_q, bad3_q, neg4_q, bad4_q, neg5_q, bad5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q   <= sc[NCell].root[30:0];
      t3_q   <= {1'b0, ssum_q[NCell-1]} + {1'b0, sc[NCell].root[30:0], 1'b0};
      sum3_q <= ssum_q[NCell-1];
      a3_q   <= sa_q[NCell-1];
      c3_q   <= sc2_q[NCell-1];
      b3_q   <= sb_q[NCell-1];
      neg3_q <= sneg_q[NCell-1];
      bad3_q <= sbad_q[NCell-1];
      den4_q <= s3_q * t3_q;
      sq4_q  <= sum3_q * sum3_q;
      ss4_q  <= s3_q * s3_q;
      s4_q   <= s3_q;
      t4_q   <= t3_q;
      a4_q   <= a3_q;
      c4_q   <= c3_q;
      b4_q   <= b3_q;
      neg4_q <= neg3_q;
      bad4_q <= bad3_q;
      den5_q <= den4_q;
      rr5_q  <= sq4_q - {ss4_q, 2'b00};
      s5_q   <= s4_q;
      t5_q   <= t4_q;
      a5_q   <= a4_q;
      c5_q   <= c4_q;
      b5_q   <= b4_q;
      neg5_q <= neg4_q;
      bad5_q <= bad4_q;
    end
  end

  // roots q and r side by side
  sqrt_t qc [NCell+1];
  sqrt_t rc [NCell+1];
  logic [30:0] qa_q [NCell];
  logic [30:0] qcc_q [NCell];
  logic [30:0] qb_q [NCell];
  logic [30:0] qs_q [NCell];
  logic [32:0] qt_q [NCell];
  logic        qneg_q [NCell];
  logic        qbad_q [NCell];

  assign qc[0] = '{val: den5_q, rem: '0, root: '0};
  assign rc[0] = '{val: rr5_q, rem: '0, root: '0};

  for (genvar k = 0; k < NCell; k++) begin : g_qroot
    s2isn_sqrt_cell u_qcell (.clk_i(clk_i), .en_i(en), .d_i(qc[k]), .q_o(qc[k+1]));
    s2isn_sqrt_cell u_rcell (.clk_i(clk_i), .en_i(en), .d_i(rc[k]), .q_o(rc[k+1]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        qa_q[k]   <= (k == 0) ? a5_q   : qa_q[k == 0 ? 0 : k-1];
        qcc_q[k]  <= (k == 0) ? c5_q   : qcc_q[k == 0 ? 0 : k-1];
        qb_q[k]   <= (k == 0) ? b5_q   : qb_q[k == 0 ? 0 : k-1];
        qs_q[k]   <= (k == 0) ? s5_q   : qs_q[k == 0 ? 0 : k-1];
        qt_q[k]   <= (k == 0) ? t5_q   : qt_q[k == 0 ? 0 : k-1];
        qneg_q[k] <= (k == 0) ? neg5_q : qneg_q[k == 0 ? 0 : k-1];
        qbad_q[k] <= (k == 0) ? bad5_q : qbad_q[k == 0 ? 0 : k-1];
      end
    end
  end

  // numerators, then rounded dividends and overflow flags
  logic [NumW-1:0] nm6_q [NumDiv];
  logic [31:0]     q6_q;
  logic            neg6_q, bad6_q, neg7_q, bad7_q;
  logic [NumDiv-1:0] ovf7_q;
  div_t            dv7_q [NumDiv];
  logic [31:0]     qv_w, rv_w;
  logic [32:0]     tv_w;
  logic [30:0]     sv_w;

  assign qv_w = qc[NCell].root;
  assign rv_w = rc[NCell].root;
  assign tv_w = qt_q[NCell-1];
  assign sv_w = qs_q[NCell-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm6_q[0] <= NumW'({1'b0, qcc_q[NCell-1]} + {1'b0, sv_w});
      nm6_q[1] <= NumW'(qb_q[NCell-1]);
      nm6_q[2] <= NumW'({1'b0, qa_q[NCell-1]} + {1'b0, sv_w});
      nm6_q[3] <= {1'b0, tv_w} + {2'b00, rv_w};
      nm6_q[4] <= {1'b0, tv_w} - {2'b00, rv_w};
      q6_q     <= qv_w;
      neg6_q   <= qneg_q[NCell-1];
      bad6_q   <= qbad_q[NCell-1];
      neg7_q   <= neg6_q;
      bad7_q   <= bad6_q;
    end
  end

  for (genvar j = 0; j < NumDiv; j++) begin : g_dvin
    logic [DenW-1:0]   dn_w;
    logic [DividW-1:0] dd_w;
    assign dn_w = (j < 3) ? {1'b0, q6_q} : {q6_q, 1'b0};
    assign dd_w = {1'b0, nm6_q[j], {OutFrac{1'b0}}} + DividW'(dn_w >> 1);
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv7_q[j].num <= dd_w[QuoW-1:0];
        dv7_q[j].rem <= DenW'(dd_w[DividW-1:QuoW]);
        dv7_q[j].quo <= '0;
        dv7_q[j].den <= dn_w;
        ovf7_q[j]    <= DenW'(dd_w[DividW-1:QuoW]) >= dn_w;
      end
    end
  end

  // five divider chains
  div_t dc [NumDiv][NCell+1];
  logic [NumDiv-1:0] dovf_q [NCell];
  logic              dneg_q [NCell];
  logic              dbad_q [NCell];

  for (genvar j = 0; j < NumDiv; j++) begin : g_div
    assign dc[j][0] = dv7_q[j];
    for (genvar k = 0; k < NCell; k++) begin : g_cell
      s2isn_div_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(dc[j][k]), .q_o(dc[j][k+1]));
    end
  end

  for (genvar k = 0; k < NCell; k++) begin : g_dside
    always_ff @(posedge clk_i) begin
      if (en) begin
        dovf_q[k] <= (k == 0) ? ovf7_q : dovf_q[k == 0 ? 0 : k-1];
        dneg_q[k] <= (k == 0) ? neg7_q : dneg_q[k == 0 ? 0 : k-1];
        dbad_q[k] <= (k == 0) ? bad7_q : dbad_q[k == 0 ? 0 : k-1];
      end
    end
  end

  // saturation and output register
  logic [30:0] sat_w [NumDiv];
  logic [31:0] mag_w, xy_w;
  logic [NumDiv-1:0] fovf_w;
  logic        fbad_w;

  assign fovf_w = dovf_q[NCell-1];
  assign fbad_w = dbad_q[NCell-1];

  for (genvar j = 0; j < NumDiv; j++) begin : g_sat
    assign sat_w[j] = (fovf_w[j] || dc[j][NCell].quo[31]) ? 31'h7fff_ffff
                                                          : dc[j][NCell].quo[30:0];
  end

  always_comb begin
    if (fovf_w[1] || (dc[1][NCell].quo > 32'h8000_0000)) begin
      mag_w = 32'h8000_0000;
    end else begin
      mag_w = dc[1][NCell].quo;
    end
    // negative b gives a positive off-diagonal entry
    xy_w = dneg_q[NCell-1] ? {1'b0, sat_w[1]} : (32'd0 - mag_w);
  end

  logic [30:0] rxx_q, ryy_q, fl_q, fs_q;
  logic [31:0] rxy_q;
  logic        st_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rxx_q <= fbad_w ? '0 : sat_w[0];
      rxy_q <= fbad_w ? '0 : xy_w;
      ryy_q <= fbad_w ? '0 : sat_w[2];
      fl_q  <= fbad_w ? '0 : sat_w[3];
      fs_q  <= fbad_w ? '0 : sat_w[4];
      st_q  <= fbad_w;
    end
  end

  assign out_valid_o    = vld_q[NStage-1];
  assign root_xx_o      = rxx_q;
  assign root_xy_o      = rxy_q;
  assign root_yy_o      = ryy_q;
  assign factor_large_o = fl_q;
  assign factor_small_o = fs_q;
  assign status_o       = st_q;

  `S2ISN_ASSERT_IMP(a_bad_zero, out_valid_o && status_o,
    root_xx_o == '0 && root_xy_o == '0 && root_yy_o == '0 && factor_large_o == '0)
  `S2ISN_ASSERT_IMP(a_factor_order, out_valid_o && !status_o,
    factor_large_o >= factor_small_o)
  `S2ISN_ASSERT_NEVER(a_stall_only_full, in_stall_o && !out_valid_o)
endmodule
`default_nettype wire
